>>> rtl/core/lqrgs_pkg.sv
// lqrgs_pkg: shared types, constants and the microcode table of the gain-scheduled
// lqr feedback unit
// no dependencies
package lqrgs_pkg;

  // default sizing
  localparam int STATE_ELEMENTS_DEF = 6;
  localparam int POLY_TERMS_DEF     = 4;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int LEG_W       = 16;
  localparam int ELEM_IDX_W  = 3;
  localparam int COEF_IDX_W  = 6;

  // microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_READ0  = 3'd0;  // fetch leading coefficient
  localparam step_t STEP_LOAD   = 3'd1;  // acc = leading coefficient
  localparam step_t STEP_MUL    = 3'd2;  // prod = acc * leg length
  localparam step_t STEP_HORNER = 3'd3;  // acc = sat32(rnd(prod) + coef)
  localparam step_t STEP_GMUL   = 3'd4;  // prod = gain * error
  localparam step_t STEP_ACCUM  = 3'd5;  // accumulator += rnd(prod)
  localparam step_t STEP_FINISH = 3'd6;  // emit torques on last element

  typedef enum logic [1:0] {
    JC_NONE,
    JC_TERM_MORE,
    JC_ROW_LO
  } jump_cond_t;

  typedef struct packed {
    logic       rd_en;
    logic       rd_ahead;
    logic       acc_load;
    logic       term_inc;
    logic       mul_en;
    logic       mul_err;
    logic       horner;
    logic       accum;
    logic       finish;
    jump_cond_t jump_cond;
    step_t      jump_to;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = '0;
    case (step)
      STEP_READ0: begin
        cw.rd_en = 1'b1;
      end
      STEP_LOAD: begin
        cw.acc_load = 1'b1;
        cw.rd_en    = 1'b1;
        cw.rd_ahead = 1'b1;
        cw.term_inc = 1'b1;
      end
      STEP_MUL: begin
        cw.mul_en = 1'b1;
      end
      STEP_HORNER: begin
        cw.horner    = 1'b1;
        cw.rd_en     = 1'b1;
        cw.rd_ahead  = 1'b1;
        cw.term_inc  = 1'b1;
        cw.jump_cond = JC_TERM_MORE;
        cw.jump_to   = STEP_MUL;
      end
      STEP_GMUL: begin
        cw.mul_en  = 1'b1;
        cw.mul_err = 1'b1;
      end
      STEP_ACCUM: begin
        cw.accum     = 1'b1;
        cw.jump_cond = JC_ROW_LO;
        cw.jump_to   = STEP_READ0;
      end
      STEP_FINISH: begin
        cw.finish = 1'b1;
      end
      default: begin
        cw.finish = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/core/lqrgs_ram.sv
// lqrgs_ram: generic single-write, single-read ram with registered read data
// depends on lqrgs_pkg for the default width
module lqrgs_ram #(
  parameter int WIDTH = lqrgs_pkg::DATA_W,
  parameter int DEPTH = 2 * lqrgs_pkg::STATE_ELEMENTS_DEF * lqrgs_pkg::POLY_TERMS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lqrgs_sequencer.sv
// lqrgs_sequencer: step counter, microcode fetch, term and row counters, jumps
// depends on lqrgs_pkg (ctrl_t, ucode)
module lqrgs_sequencer #(
  parameter int POLY_TERMS = lqrgs_pkg::POLY_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          start_last,
  input  logic                          out_full,
  output logic                          busy,
  output lqrgs_pkg::ctrl_t              ctrl,
  output logic [$clog2(POLY_TERMS)-1:0] term,
  output logic                          term_last,
  output logic                          row_sel,
  output logic                          emit
);
  import lqrgs_pkg::*;

  localparam int TW = $clog2(POLY_TERMS);

  step_t pc;
  logic  last;
  ctrl_t cw;
  logic  taken;
  logic  hold;

  assign cw        = ucode(pc);
  assign term_last = (term == TW'(POLY_TERMS - 1));
  assign ctrl      = busy ? cw : '0;

  always_comb begin
    case (cw.jump_cond)
      JC_NONE:      taken = 1'b0;
      JC_TERM_MORE: taken = !term_last;
      JC_ROW_LO:    taken = !row_sel;
      default:      taken = 1'b0;
    endcase
  end

  // wait at the finish step of a last element while the previous result is still unread
  assign hold = cw.finish && last && out_full;
  assign emit = busy && cw.finish && last && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pc      <= STEP_READ0;
      term    <= '0;
      row_sel <= 1'b0;
      last    <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      pc      <= STEP_READ0;
      term    <= '0;
      row_sel <= 1'b0;
      last    <= start_last;
    end else if (busy) begin
      if (cw.term_inc) begin
        term <= term + TW'(1);
      end
      if (cw.jump_cond == JC_ROW_LO && taken) begin
        row_sel <= 1'b1;
        term    <= '0;
      end
      if (hold) begin
        pc <= pc;
      end else if (cw.finish) begin
        busy <= 1'b0;
      end else if (taken) begin
        pc <= cw.jump_to;
      end else begin
        pc <= pc + step_t'(1);
      end
    end
  end

endmodule

>>> rtl/core/lqrgs_datapath.sv
// lqrgs_datapath: operand registers, shared multiplier, rounding, saturation,
// foot and hip accumulators and the output register; depends on lqrgs_pkg
module lqrgs_datapath #(
  parameter int STATE_ELEMENTS = lqrgs_pkg::STATE_ELEMENTS_DEF,
  parameter int POLY_TERMS     = lqrgs_pkg::POLY_TERMS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic                                       clear,
  input  logic [lqrgs_pkg::LEG_W-1:0]                leg_length,
  input  logic [lqrgs_pkg::ELEM_IDX_W-1:0]           element_index,
  input  logic signed [lqrgs_pkg::DATA_W-1:0]        measured,
  input  logic signed [lqrgs_pkg::DATA_W-1:0]        target,
  input  lqrgs_pkg::ctrl_t                           ctrl,
  input  logic [$clog2(POLY_TERMS)-1:0]              term,
  input  logic                                       term_last,
  input  logic                                       row_sel,
  input  logic                                       emit,
  output logic                                       rd_en,
  output logic [$clog2(2*STATE_ELEMENTS*POLY_TERMS)-1:0] rd_addr,
  input  logic signed [lqrgs_pkg::DATA_W-1:0]        rd_data,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output logic signed [lqrgs_pkg::DATA_W-1:0]        foot_torque,
  output logic signed [lqrgs_pkg::DATA_W-1:0]        hip_torque
);
  import lqrgs_pkg::*;

  localparam int TW    = $clog2(POLY_TERMS);
  localparam int EW    = $clog2(STATE_ELEMENTS);
  localparam int AW    = $clog2(2 * STATE_ELEMENTS * POLY_TERMS);
  localparam int ERR_W = DATA_W + 1;
  localparam int PROD_W = DATA_W + ERR_W;
  localparam int RND_W = PROD_W + 1 - 16;
  localparam int ACC_W = 64;

  logic [LEG_W-1:0]         x;
  logic signed [ERR_W-1:0]  err;
  logic [EW-1:0]            elem;
  logic signed [DATA_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  foot_acc;
  logic signed [ACC_W-1:0]  hip_acc;

  logic [TW-1:0]            term_sel;
  logic signed [ERR_W-1:0]  mul_b;
  logic signed [PROD_W:0]   prod_bias;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W:0]    hsum;
  logic signed [DATA_W-1:0] hsat;
  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [ACC_W:0]    asum;
  logic signed [ACC_W-1:0]  asat;

  // coefficient address: gain row (2*elem + row) times terms plus term
  assign term_sel = ctrl.rd_ahead ? term + TW'(1) : term;
  assign rd_en    = ctrl.rd_en && !(ctrl.rd_ahead && term_last);
  assign rd_addr  = AW'(32'({elem, row_sel}) * POLY_TERMS + 32'(term_sel));

  assign mul_b = ctrl.mul_err ? err : $signed({{(ERR_W - LEG_W){1'b0}}, x});

  // round half up: floor((p + 2^15) / 2^16)
  assign prod_bias = {prod[PROD_W-1], prod} + (PROD_W + 1)'(32768);
  assign rnd       = prod_bias[PROD_W:16];

  assign hsum = {rnd[RND_W-1], rnd}
              + {{(RND_W + 1 - DATA_W){rd_data[DATA_W-1]}}, rd_data};

  always_comb begin
    if (hsum[RND_W:DATA_W-1] == '0 || hsum[RND_W:DATA_W-1] == '1) begin
      hsat = hsum[DATA_W-1:0];
    end else if (hsum[RND_W]) begin
      hsat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      hsat = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  assign acc_sel = row_sel ? hip_acc : foot_acc;
  assign asum    = {acc_sel[ACC_W-1], acc_sel}
                 + {{(ACC_W + 1 - RND_W){rnd[RND_W-1]}}, rnd};

  always_comb begin
    if (asum[ACC_W] != asum[ACC_W-1]) begin
      asat = asum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      asat = asum[ACC_W-1:0];
    end
  end

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W - 1){1'b1}}};
    end
    return r;
  endfunction

  // operand capture and the shared multiplier
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= leg_length;
      err  <= {measured[DATA_W-1], measured} - {target[DATA_W-1], target};
      elem <= EW'(element_index);
    end
    if (ctrl.acc_load) begin
      acc <= rd_data;
    end else if (ctrl.horner) begin
      acc <= hsat;
    end
    if (ctrl.mul_en) begin
      prod <= acc * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      foot_acc <= '0;
      hip_acc  <= '0;
    end else if (clear) begin
      foot_acc <= '0;
      hip_acc  <= '0;
    end else if (ctrl.accum) begin
      if (row_sel) begin
        hip_acc <= asat;
      end else begin
        foot_acc <= asat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      foot_torque <= sat_out(foot_acc);
      hip_torque  <= sat_out(hip_acc);
    end
  end

endmodule

>>> rtl/core/lqr_gain_scheduled_feedback_unit.sv
// lqr_gain_scheduled_feedback_unit: top level of the gain-scheduled lqr feedback unit
// depends on lqrgs_pkg, lqrgs_ram, lqrgs_sequencer, lqrgs_datapath
//
// Gain-scheduled LQR state feedback for one wheel-leg joint. Load items (mode 1) write
// one Q16.16 polynomial coefficient into a table of 2*STATE_ELEMENTS gain rows by
// POLY_TERMS terms (term 0 is the highest power) and do not make the unit busy; an index past
// the table is dropped. Feedback items (mode 0) carry the leg length and one state
// element, in index order: for element e the foot gain (row 2e) and hip gain (row 2e+1)
// are evaluated at the leg length by Horner's rule, each multiplied by
// (measured - target) and added into a saturating 64-bit accumulator; element 0 clears
// both accumulators first, and the last element emits foot and hip torque saturated to
// 32 bits. An element index past the last is accepted and ignored. Every coefficient a
// feedback item uses must have been loaded first. A feedback item keeps the unit busy
// until its microprogram finishes, so no new item is taken meanwhile: one 32x33
// multiplier is shared by every Horner step and both gain products, with one
// coefficient ram read per term. The result sits in an output register, so the next
// transaction is taken while it waits; the unit only stalls at the end of a last
// element if the previous result has not been taken yet.
module lqr_gain_scheduled_feedback_unit #(
  parameter int STATE_ELEMENTS = lqrgs_pkg::STATE_ELEMENTS_DEF,
  parameter int POLY_TERMS     = lqrgs_pkg::POLY_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [lqrgs_pkg::LEG_W-1:0]         leg_length,
  input  logic [lqrgs_pkg::ELEM_IDX_W-1:0]    element_index,
  input  logic signed [lqrgs_pkg::DATA_W-1:0] measured,
  input  logic signed [lqrgs_pkg::DATA_W-1:0] target,
  input  logic [lqrgs_pkg::COEF_IDX_W-1:0]    coef_index,
  input  logic signed [lqrgs_pkg::DATA_W-1:0] coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lqrgs_pkg::DATA_W-1:0] foot_torque,
  output logic signed [lqrgs_pkg::DATA_W-1:0] hip_torque
);
  import lqrgs_pkg::*;

  localparam int DEPTH = 2 * STATE_ELEMENTS * POLY_TERMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(POLY_TERMS);

  logic          accept;
  logic          elem_in_range;
  logic          start;
  logic          start_last;
  logic          clear;
  logic          wr_en;
  logic          busy;
  ctrl_t         ctrl;
  logic [TW-1:0] term;
  logic          term_last;
  logic          row_sel;
  logic          emit;
  logic          out_full;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  // one transaction at a time through the sequencer
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  // feedback item: start the microprogram, element 0 clears the accumulators
  assign elem_in_range = (32'(element_index) < STATE_ELEMENTS);
  assign start         = accept && !mode && elem_in_range;
  assign start_last    = (32'(element_index) == STATE_ELEMENTS - 1);
  assign clear         = start && (element_index == '0);

  // load item: write the coefficient if the index is inside the table
  assign wr_en = accept && mode && (32'(coef_index) < DEPTH);

  // a result still waiting blocks the next emit
  assign out_full = out_valid && !out_ready;

  lqrgs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lqrgs_sequencer #(
    .POLY_TERMS (POLY_TERMS)
  ) u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_last (start_last),
    .out_full   (out_full),
    .busy       (busy),
    .ctrl       (ctrl),
    .term       (term),
    .term_last  (term_last),
    .row_sel    (row_sel),
    .emit       (emit)
  );

  lqrgs_datapath #(
    .STATE_ELEMENTS (STATE_ELEMENTS),
    .POLY_TERMS     (POLY_TERMS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .clear         (clear),
    .leg_length    (leg_length),
    .element_index (element_index),
    .measured      (measured),
    .target        (target),
    .ctrl          (ctrl),
    .term          (term),
    .term_last     (term_last),
    .row_sel       (row_sel),
    .emit          (emit),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .foot_torque   (foot_torque),
    .hip_torque    (hip_torque)
  );

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for lqr_gain_scheduled_feedback_unit
// holds a torque predictor in a small scoreboard class, drives both handshakes with random pacing
// depends on lqrgs_pkg and the rtl of the unit
module testbench;
  import lqrgs_pkg::*;

  // sizing of the unit under test, kept at the package defaults
  localparam int ELEMENTS     = STATE_ELEMENTS_DEF;
  localparam int TERMS        = POLY_TERMS_DEF;
  localparam int TABLE_DEPTH  = 2 * ELEMENTS * TERMS;
  localparam int BUSY_CYCLES  = 4 * TERMS + 5;   // busy time of one feedback item
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 400000;          // well above the slowest legal run

  // item kinds carried by the mode field
  localparam logic MODE_FEEDBACK = 1'b0;
  localparam logic MODE_LOAD     = 1'b1;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  // receiver stall styles, picked anew at random at regular intervals
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_LONG_STALLS
  } rx_style_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] foot;
    logic signed [DATA_W-1:0] hip;
  } torque_pair_t;

  // torque predictor plus the queue of torques still owed by the unit
  class torque_scoreboard;
    logic signed [DATA_W-1:0] coef_table [TABLE_DEPTH];
    logic signed [63:0]       foot_acc;
    logic signed [63:0]       hip_acc;
    torque_pair_t             expected_torques [$];
    int                       errors;

    function new();
      foreach (coef_table[i]) coef_table[i] = '0;
      foot_acc = '0;
      hip_acc  = '0;
      errors   = 0;
    endfunction

    // floor((v + 2^15) / 2^16), i.e. round half up
    function logic signed [65:0] round_q16(logic signed [65:0] v);
      return (v + 66'sd32768) >>> 16;
    endfunction

    function logic signed [65:0] clamp_signed(logic signed [65:0] v, int bits);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
      lo = -(66'sd1 <<< (bits - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one gain row evaluated at the leg length, highest power first
    function logic signed [65:0] horner_gain(int row, logic [LEG_W-1:0] x);
      logic signed [65:0] acc;
      int t;
      acc = 66'(coef_table[row * TERMS]);
      for (t = 1; t < TERMS; t++)
        acc = clamp_signed(round_q16(acc * 66'($signed({1'b0, x})))
                           + 66'(coef_table[row * TERMS + t]), 32);
      return acc;
    endfunction

    function void apply_item(logic m, logic [LEG_W-1:0] leg, logic [ELEM_IDX_W-1:0] elem,
                             logic signed [DATA_W-1:0] meas, logic signed [DATA_W-1:0] tgt,
                             logic [COEF_IDX_W-1:0] ci, logic signed [DATA_W-1:0] cv);
      logic signed [65:0] err;
      logic signed [65:0] gain_foot;
      logic signed [65:0] gain_hip;
      torque_pair_t       res;
      if (m == MODE_LOAD) begin
        if (ci < TABLE_DEPTH) coef_table[ci] = cv;
        return;
      end
      if (elem >= ELEMENTS) return;
      if (elem == 0) begin
        foot_acc = '0;
        hip_acc  = '0;
      end
      err       = 66'(meas) - 66'(tgt);
      gain_foot = horner_gain(int'(elem) * 2, leg);
      gain_hip  = horner_gain(int'(elem) * 2 + 1, leg);
      foot_acc  = 64'(clamp_signed(66'(foot_acc) + round_q16(gain_foot * err), 64));
      hip_acc   = 64'(clamp_signed(66'(hip_acc) + round_q16(gain_hip * err), 64));
      if (elem == ELEMENTS - 1) begin
        res.foot = 32'(clamp_signed(66'(foot_acc), 32));
        res.hip  = 32'(clamp_signed(66'(hip_acc), 32));
        expected_torques.push_back(res);
      end
    endfunction

    function void check_torques(logic signed [DATA_W-1:0] foot, logic signed [DATA_W-1:0] hip);
      torque_pair_t want;
      if (expected_torques.size() == 0) begin
        errors++;
        $display("%0t: torque result with none expected: foot %0d hip %0d",
                 $time, foot, hip);
        return;
      end
      want = expected_torques.pop_front();
      if (foot !== want.foot) begin
        errors++;
        $display("%0t: foot_torque expected %0d actual %0d",
                 $time, $signed(want.foot), foot);
      end
      if (hip !== want.hip) begin
        errors++;
        $display("%0t: hip_torque expected %0d actual %0d",
                 $time, $signed(want.hip), hip);
      end
    endfunction

    function int pending();
      return expected_torques.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic                     mode          = MODE_FEEDBACK;
  logic [LEG_W-1:0]         leg_length    = '0;
  logic [ELEM_IDX_W-1:0]    element_index = '0;
  logic signed [DATA_W-1:0] measured      = '0;
  logic signed [DATA_W-1:0] target        = '0;
  logic [COEF_IDX_W-1:0]    coef_index    = '0;
  logic signed [DATA_W-1:0] coef_value    = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [DATA_W-1:0] foot_torque;
  logic signed [DATA_W-1:0] hip_torque;

  torque_scoreboard sb;
  int               burst_left  = 0;   // transactions left before the next sender gap
  int               items_sent  = 0;   // transactions the unit acts on (ignored ones left out)
  int               cycle_count = 0;
  int               rx_count    = 0;
  rx_style_t        rx_style    = RX_ALWAYS;

  lqr_gain_scheduled_feedback_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .leg_length   (leg_length),
    .element_index(element_index),
    .measured     (measured),
    .target       (target),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .foot_torque  (foot_torque),
    .hip_torque   (hip_torque)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mix of full-range words, extremes and small values around +-2.0 so that
  // torques do not always saturate
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3, 4: return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic [LEG_W-1:0] rand_leg();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return LEG_W'($urandom);
    endcase
  endfunction

  // present one transaction, hold it until taken, then tell the predictor;
  // the sender runs in bursts and idles between them
  task automatic send_item(input logic m, input logic [LEG_W-1:0] leg,
                           input logic [ELEM_IDX_W-1:0] elem,
                           input logic signed [DATA_W-1:0] meas,
                           input logic signed [DATA_W-1:0] tgt,
                           input logic [COEF_IDX_W-1:0] ci,
                           input logic signed [DATA_W-1:0] cv);
    int gap;
    in_valid      <= 1'b1;
    mode          <= m;
    leg_length    <= leg;
    element_index <= elem;
    measured      <= meas;
    target        <= tgt;
    coef_index    <= ci;
    coef_value    <= cv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_item(m, leg, elem, meas, tgt, ci, cv);
    if ((m == MODE_LOAD) ? (ci < TABLE_DEPTH) : (elem < ELEMENTS)) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short gaps, sometimes longer than a whole feedback item
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  // unused fields of a load carry random junk
  task automatic load_coef(input logic [COEF_IDX_W-1:0] ci, input logic signed [DATA_W-1:0] cv);
    send_item(MODE_LOAD, LEG_W'($urandom), ELEM_IDX_W'($urandom), rand_word(), rand_word(),
              ci, cv);
  endtask

  // unused fields of a feedback item carry random junk
  task automatic feed_element(input logic [LEG_W-1:0] leg, input logic [ELEM_IDX_W-1:0] elem,
                              input logic signed [DATA_W-1:0] meas,
                              input logic signed [DATA_W-1:0] tgt);
    send_item(MODE_FEEDBACK, leg, elem, meas, tgt, COEF_IDX_W'($urandom), DATA_W'($urandom));
  endtask

  // elements 0..count-1 in order; count below ELEMENTS leaves a broken sequence
  task automatic feed_sequence(input logic [LEG_W-1:0] leg, input int count);
    int e;
    for (e = 0; e < count; e++)
      feed_element(($urandom_range(0, 7) == 0) ? rand_leg() : leg, ELEM_IDX_W'(e),
                   rand_word(), rand_word());
  endtask

  // stimulus
  initial begin
    int               i;
    int               pick;
    int               base;
    logic [LEG_W-1:0] leg;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table first so no feedback item reads an unwritten word;
    // a few entries take the coefficient extremes
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0 || i == 7) load_coef(COEF_IDX_W'(i), WORD_MAX);
      else if (i == 5 || i == 14) load_coef(COEF_IDX_W'(i), WORD_MIN);
      else load_coef(COEF_IDX_W'(i), rand_word());
    end

    // directed: loads past the end of the table are dropped
    load_coef(COEF_IDX_W'(TABLE_DEPTH), WORD_MAX);
    load_coef('1, WORD_MIN);
    // zero leg length, so each gain is its constant term; largest positive error
    for (i = 0; i < ELEMENTS; i++) feed_element('0, ELEM_IDX_W'(i), WORD_MAX, WORD_MIN);
    // longest leg, largest negative error
    for (i = 0; i < ELEMENTS; i++) feed_element('1, ELEM_IDX_W'(i), WORD_MIN, WORD_MAX);
    // element indexes past the last are taken and ignored
    feed_element(rand_leg(), ELEM_IDX_W'(ELEMENTS), rand_word(), rand_word());
    feed_element(rand_leg(), '1, rand_word(), rand_word());
    // last element with no fresh first element: adds onto the old totals
    feed_element(rand_leg(), ELEM_IDX_W'(ELEMENTS - 1), rand_word(), rand_word());
    // elements out of order are summed as they come
    leg = rand_leg();
    feed_element(leg, ELEM_IDX_W'(0), rand_word(), rand_word());
    feed_element(leg, ELEM_IDX_W'(3), rand_word(), rand_word());
    feed_element(leg, ELEM_IDX_W'(1), rand_word(), rand_word());
    feed_element(leg, ELEM_IDX_W'(ELEMENTS - 1), rand_word(), rand_word());

    // random: mostly complete sequences, with table updates, broken
    // sequences and stray items mixed in
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      leg  = rand_leg();
      if (pick < 72) begin
        feed_sequence(leg, ELEMENTS);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 4))
          load_coef(COEF_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_word());
      end else if (pick < 92) begin
        feed_sequence(leg, $urandom_range(1, ELEMENTS - 1));
      end else if (pick < 97) begin
        feed_element(leg, ELEM_IDX_W'($urandom_range(0, 7)), rand_word(), rand_word());
      end else begin
        load_coef(COEF_IDX_W'($urandom_range(TABLE_DEPTH, 63)), rand_word());
      end
    end

    // drain: wait for every owed torque pair, then watch a while for extras
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (BUSY_CYCLES + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: check every accepted result, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_torques(foot_torque, hip_torque);
    rx_count <= rx_count + 1;
    if (rx_count % 256 == 255) rx_style <= rx_style_t'($urandom_range(0, 2));
    case (rx_style)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ((rx_count % 13) < 4);   // long stalls between short ready windows
    endcase
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
